/* hdl/rsa_pkg.sv */
// Shared types and constants for the running statistics accumulator.
package rsa_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int COUNT_BITS  = 32;
   localparam int VAR_W       = 64;
   localparam int STEP_W      = $clog2(VAR_W + 1);

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_PROD,
      ST_SUM,
      ST_CHECK,
      ST_VAR,
      ST_PUBLISH
   } stat_state_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_cmd_type;

endpackage

/* hdl/rsa_channels_if.sv */
// Valid/ready channel interfaces for samples in and statistics out.
interface rsa_req_if;
   import rsa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, operation, sample, input ready);
   modport sink (input valid, operation, sample, output ready);
endinterface

interface rsa_rsp_if;
   import rsa_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [COUNT_BITS-1:0]  sample_count;
   logic [SAMPLE_BITS-1:0] minimum;
   logic [SAMPLE_BITS-1:0] maximum;
   logic [SAMPLE_BITS-1:0] average;
   logic [VAR_W-1:0]       spread;

   modport source (output valid, sample_count, minimum, maximum, average, spread,
                   input ready);
   modport sink (input valid, sample_count, minimum, maximum, average, spread,
                 output ready);
endinterface

/* hdl/rsa_serial_div.sv */
// Restoring divider, one quotient bit per cycle, dividend fed MSB first.
module rsa_serial_div #(
   parameter int DEN_W = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rsa_pkg::div_cmd_type      cmd,
   input  logic [DEN_W-1:0]          rem_init,
   input  logic [rsa_pkg::VAR_W-1:0] dividend,
   input  logic [DEN_W-1:0]          divisor,
   output logic                      busy,
   output logic [rsa_pkg::VAR_W-1:0] quotient
);
   import rsa_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic [DEN_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [VAR_W-1:0]    num_ff, num_in;
   logic [VAR_W-1:0]    quo_ff, quo_in;
   logic [DEN_W:0]      rem_shift;
   logic [DEN_W:0]      trial;
   logic                fits;

   assign rem_shift = {rem_ff, num_ff[VAR_W-1]};
   assign trial     = rem_shift - {1'b0, den_ff};
   assign fits      = ~trial[DEN_W];

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = rem_init;
         den_in  = divisor;
         num_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         num_in  = {num_ff[VAR_W-2:0], 1'b0};
         quo_in  = {quo_ff[VAR_W-2:0], fits};
         cnt_in  = cnt_ff - STEP_W'(1);
         busy_in = (cnt_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/rsa_serial_mul.sv */
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
module rsa_serial_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     mult_a,
   input  logic [B_W-1:0]     mult_b,
   output logic               busy,
   output logic [A_W+B_W-1:0] product
);
   import rsa_pkg::*;

   localparam int CNT_W  = $clog2(A_W + 1);
   localparam int PROD_W = A_W + B_W;

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [A_W-1:0]    a_ff, a_in;
   logic [B_W-1:0]    b_ff, b_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(A_W);
         a_in    = mult_a;
         b_in    = mult_b;
         prod_in = '0;
      end else if (busy_ff) begin
         prod_in = {prod_ff[PROD_W-2:0], 1'b0}
                 + (a_ff[A_W-1] ? PROD_W'(b_ff) : '0);
         a_in    = {a_ff[A_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      prod_ff <= prod_in;
   end

   assign busy    = busy_ff;
   assign product = prod_ff;

endmodule

/* hdl/running_statistics_accumulator_unit.sv */
// A clear or the first sample after a clear passes from acceptance through the publish state into
// the output register; a later sample runs the mean divide, the product multiply and the 64-step
// variance divide, and skips that divide when the variance saturates. One transaction is in work
// at a time; the next is taken the cycle after the result is loaded, later while the output
// register stays full.
// Reset (synchronous): count, maximum, mean, variance to zero, minimum to all ones, output empty.
module running_statistics_accumulator_unit #(
   parameter int SAMPLE_WIDTH = 32,
   parameter int COUNT_WIDTH  = 32
) (
   input logic clock,
   input logic reset,
   rsa_req_if.sink   req_chan,
   rsa_rsp_if.source rsp_chan
);
   import rsa_pkg::*;

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int ACC_W = CW + VAR_W + 1;

   stat_state_type state_ff, state_in;

   logic [CW-1:0]    count_ff, count_in;
   logic [SW-1:0]    min_ff, min_in;
   logic [SW-1:0]    max_ff, max_in;
   logic [SW-1:0]    mean_ff, mean_in;
   logic [VAR_W-1:0] var_ff, var_in;
   logic             x_ge_ff, x_ge_in;
   logic [SW-1:0]    diff_ff, diff_in;
   logic [ACC_W-1:0] sum_ff, sum_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]  out_count_ff, out_count_in;
   logic [SAMPLE_BITS-1:0] out_min_ff, out_min_in;
   logic [SAMPLE_BITS-1:0] out_max_ff, out_max_in;
   logic [SAMPLE_BITS-1:0] out_mean_ff, out_mean_in;
   logic [VAR_W-1:0]       out_var_ff, out_var_in;

   // FSM outputs
   logic accept, start_mean, start_prod, load_sum, start_var, var_sat, load_var, publish;

   logic [SW-1:0]    x;
   logic [CW-1:0]    count_m1;
   logic [SW-1:0]    step;
   logic [SW-1:0]    new_mean;
   logic             sum_over;

   div_cmd_type      div_cmd;
   logic [CW-1:0]    div_rem_init;
   logic [VAR_W-1:0] div_dividend;
   logic [CW-1:0]    div_divisor;
   logic             div_busy;
   logic [VAR_W-1:0] div_quo;

   logic             vmul_busy;
   logic [CW+VAR_W-1:0] vmul_prod;
   logic             pmul_busy;
   logic [2*SW-1:0]  pmul_prod;

   assign x        = req_chan.sample[SW-1:0];
   assign count_m1 = count_ff - CW'(1);
   assign step     = div_quo[SW-1:0];
   assign new_mean = x_ge_ff ? (mean_ff + step) : (mean_ff - step);
   assign sum_over = (sum_ff[ACC_W-1:VAR_W] >= {1'b0, count_m1});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.operation == OP_CLEAR || count_ff == '0) begin
                  state_in = ST_PUBLISH;
               end else begin
                  state_in = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            if (!div_busy && !vmul_busy) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            if (!pmul_busy) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = sum_over ? ST_PUBLISH : ST_VAR;
         end
         ST_VAR: begin
            if (!div_busy) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      accept     = 1'b0;
      start_mean = 1'b0;
      start_prod = 1'b0;
      load_sum   = 1'b0;
      start_var  = 1'b0;
      var_sat    = 1'b0;
      load_var   = 1'b0;
      publish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            accept     = req_chan.valid;
            start_mean = req_chan.valid && (req_chan.operation == OP_ADD) && (count_ff != '0);
         end
         ST_MEAN: begin
            start_prod = !div_busy && !vmul_busy;
         end
         ST_PROD: begin
            load_sum = !pmul_busy;
         end
         ST_SUM: begin
         end
         ST_CHECK: begin
            var_sat   = sum_over;
            start_var = !sum_over;
         end
         ST_VAR: begin
            load_var = !div_busy;
         end
         ST_PUBLISH: begin
            publish = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // statistics datapath
   always_comb begin
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      mean_in  = mean_ff;
      var_in   = var_ff;
      x_ge_in  = x_ge_ff;
      diff_in  = diff_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (req_chan.operation == OP_CLEAR) begin
            count_in = '0;
            min_in   = '1;
            max_in   = '0;
            mean_in  = '0;
            var_in   = '0;
         end else begin
            if (x < min_ff) begin
               min_in = x;
            end
            if (x > max_ff) begin
               max_in = x;
            end
            // saturate the count and keep folding samples in at the maximum
            count_in = (count_ff != '1) ? (count_ff + CW'(1)) : count_ff;
            if (count_ff == '0) begin
               mean_in = x;
               var_in  = '0;
            end
            x_ge_in = (x >= mean_ff);
            diff_in = (x >= mean_ff) ? (x - mean_ff) : (mean_ff - x);
         end
      end
      if (start_prod) begin
         mean_in = new_mean;
      end
      if (load_sum) begin
         sum_in = ACC_W'(vmul_prod) + ACC_W'(pmul_prod);
      end
      if (var_sat) begin
         var_in = '1;
      end
      if (load_var) begin
         var_in = div_quo;
      end
   end

   // the divider serves the mean step first, then the variance quotient
   always_comb begin
      div_cmd.start = start_mean || start_var;
      if (start_var) begin
         div_cmd.steps = STEP_W'(VAR_W);
         div_rem_init  = sum_ff[VAR_W +: CW];
         div_dividend  = sum_ff[VAR_W-1:0];
         div_divisor   = count_m1;
      end else begin
         div_cmd.steps = STEP_W'(SW);
         div_rem_init  = '0;
         div_dividend  = {diff_in, {(VAR_W-SW){1'b0}}};
         div_divisor   = count_in;
      end
   end

   rsa_serial_div #(
      .DEN_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // (n-2) * variance runs alongside the mean divide
   rsa_serial_mul #(
      .A_W (CW),
      .B_W (VAR_W)
   ) u_var_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_mean),
      .mult_a  (count_in - CW'(2)),
      .mult_b  (var_ff),
      .busy    (vmul_busy),
      .product (vmul_prod)
   );

   // |x - old mean| * |x - new mean|; the second factor is diff minus step
   rsa_serial_mul #(
      .A_W (SW),
      .B_W (SW)
   ) u_prod_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_prod),
      .mult_a  (diff_ff - step),
      .mult_b  (diff_ff),
      .busy    (pmul_busy),
      .product (pmul_prod)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_count_in = out_count_ff;
      out_min_in   = out_min_ff;
      out_max_in   = out_max_ff;
      out_mean_in  = out_mean_ff;
      out_var_in   = out_var_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (publish) begin
         rsp_valid_in = 1'b1;
         out_count_in = COUNT_BITS'(count_ff);
         out_min_in   = SAMPLE_BITS'(min_ff);
         out_max_in   = SAMPLE_BITS'(max_ff);
         out_mean_in  = SAMPLE_BITS'(mean_ff);
         out_var_in   = var_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         mean_ff      <= '0;
         var_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ge_ff      <= x_ge_in;
      diff_ff      <= diff_in;
      sum_ff       <= sum_in;
      out_count_ff <= out_count_in;
      out_min_ff   <= out_min_in;
      out_max_ff   <= out_max_in;
      out_mean_ff  <= out_mean_in;
      out_var_ff   <= out_var_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sample_count = out_count_ff;
   assign rsp_chan.minimum      = out_min_ff;
   assign rsp_chan.maximum      = out_max_ff;
   assign rsp_chan.average      = out_mean_ff;
   assign rsp_chan.spread       = out_var_ff;

endmodule
